>>> rtl/sbrp_pkg.sv
// Shared types and constants for the STUN binding response parser.
package sbrp_pkg;

  localparam int MAX_DATAGRAM = 2048;
  localparam int CNT_W        = $clog2(MAX_DATAGRAM + 1);
  localparam int HDR_LEN      = 20;
  localparam int START_W      = 17;
  localparam int PADDR_W      = 4;

  localparam logic [15:0] STUN_SUCCESS    = 16'h0101;
  localparam logic [15:0] ATTR_MAPPED     = 16'h0001;
  localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
  localparam logic [31:0] STUN_COOKIE     = 32'h2112A442;
  localparam logic [7:0]  FAMILY_V4       = 8'h01;
  localparam logic [7:0]  FAMILY_V6       = 8'h02;

  localparam logic [0:0] REG_TXID_HIGH = 1'b0;
  localparam logic [0:0] REG_TXID_LOW  = 1'b1;

  typedef enum logic [1:0] {
    ST_IPV4    = 2'd0,
    ST_IPV6    = 2'd1,
    ST_BAD     = 2'd2,
    ST_NO_ADDR = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    WALK_ON   = 2'd0,
    WALK_V4   = 2'd1,
    WALK_V6   = 2'd2,
    WALK_STOP = 2'd3
  } walk_e;

  typedef struct packed {
    status_e      status;
    logic [63:0]  addr_high;
    logic [63:0]  addr_low;
  } result_t;

endpackage

>>> rtl/stun_binding_response_parser_unit.sv
// Top level of the STUN binding response parser.
//
//  channel   dir  handshake                 payload
//  in        in   in_valid_i / in_stall_o   data_byte_i, last_byte_i
//  out       out  out_valid_o / out_stall_i status_o, addr_high_o, addr_low_o
//  cfg       in   APB psel/penable/pready   paddr, pwdata, prdata
//
//  One byte beat per cycle when not stalled; the last byte's result is registered.
//  All per-byte work is a single pass of compares and a byte write into the parse state.
//  in_stall_o rises only when the output register and its skid entry are both full.
//  Reset clears the parse state and the transaction id registers.
module stun_binding_response_parser_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [63:0]                  addr_high_o,
  output logic [63:0]                  addr_low_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbrp_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  import sbrp_pkg::*;

  logic        in_accept;
  logic        res_valid;
  result_t     res;
  result_t     out_data;
  logic [31:0] txid_high;
  logic [63:0] txid_low;

  assign in_accept = in_valid_i && !in_stall_o;

  sbrp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .txid_high_o (txid_high),
    .txid_low_o  (txid_low)
  );

  sbrp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .txid_high_i (txid_high),
    .txid_low_i  (txid_low),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sbrp_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .full_o      (in_stall_o)
  );

  assign status_o    = out_data.status;
  assign addr_high_o = out_data.addr_high;
  assign addr_low_o  = out_data.addr_low;

endmodule

>>> rtl/sbrp_cfg_regs.sv
// Transaction id registers behind the APB-style configuration port.
module sbrp_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbrp_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  output logic [31:0]                 txid_high_o,
  output logic [63:0]                 txid_low_o
);
  import sbrp_pkg::*;

  logic [31:0] txid_high_q, txid_high_d;
  logic [63:0] txid_low_q, txid_low_d;
  logic        wr_en;
  logic [0:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3];

  always_comb begin
    txid_high_d = txid_high_q;
    txid_low_d  = txid_low_q;
    if (wr_en) begin
      case (reg_idx)
        REG_TXID_HIGH: txid_high_d = pwdata[31:0];
        REG_TXID_LOW:  txid_low_d  = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TXID_HIGH: prdata = {32'h0, txid_high_q};
      REG_TXID_LOW:  prdata = txid_low_q;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      txid_high_q <= '0;
      txid_low_q  <= '0;
    end else begin
      txid_high_q <= txid_high_d;
      txid_low_q  <= txid_low_d;
    end
  end

  assign txid_high_o = txid_high_q;
  assign txid_low_o  = txid_low_q;

endmodule

>>> rtl/sbrp_parser.sv
// Per-byte header check and attribute walk; emits one result on the last byte.
module sbrp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic [31:0]       txid_high_i,
  input  logic [63:0]       txid_low_i,
  output logic              res_valid_o,
  output sbrp_pkg::result_t res_o
);
  import sbrp_pkg::*;

  logic [CNT_W-1:0]   byte_count_q, byte_count_d;
  logic [15:0]        msg_len_q, msg_len_d;
  logic               header_ok_q, header_ok_d;
  logic [START_W-1:0] attr_start_q, attr_start_d;
  logic [15:0]        attr_type_q, attr_type_d;
  logic [15:0]        attr_len_q, attr_len_d;
  logic [7:0]         attr_family_q, attr_family_d;
  logic [127:0]       addr_buf_q, addr_buf_d;
  walk_e              walk_q, walk_d;

  logic [START_W-1:0] pos_ext, off, val_idx, limit;
  logic [START_W:0]   hdr_end, attr_end, next_start;
  logic [15:0]        len_new;
  logic [159:0]       hdr_exp;
  logic [4:0]         hdr_sel;
  logic [3:0]         buf_sel;
  logic               in_dgram, in_walk, finish, is_addr, xored;

  // state as it stands after this byte, before the end-of-datagram clear
  logic [CNT_W-1:0]   fin_count;
  logic               fin_ok;
  walk_e              fin_walk;
  logic [127:0]       fin_buf;

  assign pos_ext  = START_W'(byte_count_q);
  assign off      = pos_ext - attr_start_q;
  assign val_idx  = off - START_W'(4);
  assign limit    = START_W'(HDR_LEN) + {1'b0, msg_len_q};
  assign len_new  = {attr_len_q[15:8], data_byte_i};
  assign hdr_end  = {1'b0, attr_start_q} + (START_W + 1)'(4);
  assign attr_end = hdr_end + {2'b00, len_new};
  assign hdr_exp  = {STUN_SUCCESS, 16'h0000, STUN_COOKIE, txid_high_i, txid_low_i};
  assign hdr_sel  = 5'd19 - byte_count_q[4:0];
  assign buf_sel  = 4'(5'd19 - val_idx[4:0]);
  assign in_dgram = byte_count_q < CNT_W'(MAX_DATAGRAM);
  assign in_walk  = (walk_q == WALK_ON) && (pos_ext >= attr_start_q);
  assign is_addr  = (attr_type_q == ATTR_MAPPED) || (attr_type_q == ATTR_XOR_MAPPED);
  assign xored    = attr_type_q == ATTR_XOR_MAPPED;

  // byte update
  always_comb begin
    byte_count_d  = byte_count_q;
    msg_len_d     = msg_len_q;
    header_ok_d   = header_ok_q;
    attr_start_d  = attr_start_q;
    attr_type_d   = attr_type_q;
    attr_len_d    = attr_len_q;
    attr_family_d = attr_family_q;
    addr_buf_d    = addr_buf_q;
    walk_d        = walk_q;
    finish        = 1'b0;
    next_start    = '0;
    if (accept_i && in_dgram) begin
      byte_count_d = byte_count_q + CNT_W'(1);
      if (byte_count_q < CNT_W'(HDR_LEN)) begin
        if (byte_count_q == CNT_W'(2)) begin
          msg_len_d = {data_byte_i, 8'h00};
        end else if (byte_count_q == CNT_W'(3)) begin
          msg_len_d = {msg_len_q[15:8], data_byte_i};
        end else if (data_byte_i != hdr_exp[{hdr_sel, 3'b000} +: 8]) begin
          header_ok_d = 1'b0;
        end
      end else if (in_walk) begin
        case (off)
          START_W'(0): begin
            if (hdr_end > {1'b0, limit}) begin
              walk_d = WALK_STOP;
            end else begin
              attr_type_d   = {data_byte_i, 8'h00};
              attr_len_d    = '0;
              attr_family_d = '0;
              addr_buf_d    = '0;
            end
          end
          START_W'(1): attr_type_d = {attr_type_q[15:8], data_byte_i};
          START_W'(2): attr_len_d  = {data_byte_i, 8'h00};
          START_W'(3): begin
            attr_len_d = len_new;
            if (attr_end > {1'b0, limit}) begin
              walk_d = WALK_STOP;
            end else if (len_new == 16'h0) begin
              finish = 1'b1;
            end
          end
          default: begin
            if (val_idx == START_W'(1)) attr_family_d = data_byte_i;
            if (val_idx >= START_W'(4) && val_idx < START_W'(20)) begin
              addr_buf_d[{buf_sel, 3'b000} +: 8] = data_byte_i;
            end
            if (val_idx + START_W'(1) == {1'b0, attr_len_q}) finish = 1'b1;
          end
        endcase
        if (finish) begin
          if (is_addr && attr_len_d >= 16'd8 && attr_family_d == FAMILY_V4) begin
            addr_buf_d = {96'h0, addr_buf_d[127:96] ^ (xored ? STUN_COOKIE : 32'h0)};
            walk_d     = WALK_V4;
          end else if (is_addr && attr_len_d >= 16'd20 && attr_family_d == FAMILY_V6) begin
            if (xored) addr_buf_d = addr_buf_d ^ {STUN_COOKIE, txid_high_i, txid_low_i};
            walk_d = WALK_V6;
          end else begin
            next_start   = (hdr_end + {1'b0, START_W'(attr_len_d) + START_W'(3)}) &
                           {{(START_W - 1){1'b1}}, 2'b00};
            attr_start_d = next_start[START_W-1:0];
          end
        end
      end
    end
    fin_count = byte_count_d;
    fin_ok    = header_ok_d;
    fin_walk  = walk_d;
    fin_buf   = addr_buf_d;
    if (accept_i && last_byte_i) begin
      byte_count_d  = '0;
      msg_len_d     = '0;
      header_ok_d   = 1'b1;
      attr_start_d  = START_W'(HDR_LEN);
      attr_type_d   = '0;
      attr_len_d    = '0;
      attr_family_d = '0;
      addr_buf_d    = '0;
      walk_d        = WALK_ON;
    end
  end

  always_comb begin
    res_valid_o      = accept_i && last_byte_i;
    res_o.addr_high  = '0;
    res_o.addr_low   = '0;
    if (fin_count < CNT_W'(HDR_LEN) || !fin_ok) begin
      res_o.status = ST_BAD;
    end else begin
      case (fin_walk)
        WALK_V4: begin
          res_o.status    = ST_IPV4;
          res_o.addr_high = fin_buf[127:64];
          res_o.addr_low  = fin_buf[63:0];
        end
        WALK_V6: begin
          res_o.status    = ST_IPV6;
          res_o.addr_high = fin_buf[127:64];
          res_o.addr_low  = fin_buf[63:0];
        end
        default: res_o.status = ST_NO_ADDR;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= '0;
      msg_len_q     <= '0;
      header_ok_q   <= 1'b1;
      attr_start_q  <= START_W'(HDR_LEN);
      attr_type_q   <= '0;
      attr_len_q    <= '0;
      attr_family_q <= '0;
      addr_buf_q    <= '0;
      walk_q        <= WALK_ON;
    end else begin
      byte_count_q  <= byte_count_d;
      msg_len_q     <= msg_len_d;
      header_ok_q   <= header_ok_d;
      attr_start_q  <= attr_start_d;
      attr_type_q   <= attr_type_d;
      attr_len_q    <= attr_len_d;
      attr_family_q <= attr_family_d;
      addr_buf_q    <= addr_buf_d;
      walk_q        <= walk_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= CNT_W'(MAX_DATAGRAM))
    else $error("byte count past max datagram");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_byte_i |=> byte_count_q == '0 && walk_q == WALK_ON && header_ok_q)
    else $error("state not cleared after last beat");

endmodule

>>> rtl/sbrp_out_buf.sv
// Result register with skid entry on the output channel.
module sbrp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sbrp_pkg::result_t push_data_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output sbrp_pkg::result_t out_data_o,
  output logic              full_o
);
  import sbrp_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = push_data_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign full_o      = skid_valid_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && skid_valid_q))
    else $error("result pushed into full output buffer");

endmodule
